@@ rtl/qpc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// qpc_pkg: shared types and constants for the quasi-periodic covariance block
// Fixed-point constants, register indexes, reciprocal multipliers.
// ============================================================================
package qpc_pkg;

    localparam int NUM_STAGES = 31;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_AMPLITUDE  = 3'd1,
        CFG_INV_LENGTH = 3'd2,
        CFG_PHASE      = 3'd3,
        CFG_GAIN       = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
    } tag_t;

    // register reset values
    localparam logic [31:0]        RST_AMPLITUDE  = 32'd65536;
    localparam logic [31:0]        RST_INV_LENGTH = 32'd16777216;
    localparam logic [31:0]        RST_PHASE      = 32'd52707179;
    localparam logic signed [31:0] RST_GAIN       = -32'sd33554432;

    // fixed-point constants
    localparam logic [31:0] ONE30     = 32'h4000_0000;
    localparam logic [41:0] PI40      = 42'h3243F6A8886;
    localparam logic [41:0] HALF_PI40 = PI40 >> 1;
    localparam logic [43:0] PI40_X2   = {1'b0, PI40, 1'b0};
    localparam logic [43:0] PI40_X1   = {2'b00, PI40};
    localparam logic [31:0] LOG2E30   = 32'h5C551D95;
    localparam logic [29:0] LN2_30    = 30'h2C5C85FE;
    localparam logic signed [29:0] EXP_MIN   = -30'sd2097152;
    localparam logic [27:0]        DECAY_CAP = 28'h800_0000;

    // floor(2^64 / pi40) for phase reduction
    localparam logic [64:0] TWO64     = 65'd1 << 64;
    localparam logic [22:0] PI_RECIP  = 23'(TWO64 / 65'(PI40));

    // exact floor(v/d) for v < 2^32: (v * ceil(2^(32+l)/d)) >> (32+l)
    localparam logic [5:0]  SH72 = 6'd39;
    localparam logic [32:0] M72  = 33'(((65'd1 << 39) + 65'd71) / 65'd72);
    localparam logic [5:0]  SH42 = 6'd38;
    localparam logic [32:0] M42  = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
    localparam logic [5:0]  SH20 = 6'd37;
    localparam logic [32:0] M20  = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
    localparam logic [5:0]  SH6  = 6'd35;
    localparam logic [32:0] M6   = 33'(((65'd1 << 35) + 65'd5) / 65'd6);
    localparam logic [5:0]  SH7  = 6'd35;
    localparam logic [32:0] M7   = 33'(((65'd1 << 35) + 65'd6) / 65'd7);
    localparam logic [5:0]  SH5  = 6'd35;
    localparam logic [32:0] M5   = 33'(((65'd1 << 35) + 65'd4) / 65'd5);
    localparam logic [5:0]  SH3  = 6'd34;
    localparam logic [32:0] M3   = 33'(((65'd1 << 34) + 65'd2) / 65'd3);

    function automatic logic [31:0] mul_shr(input logic [31:0] v, input logic [32:0] m,
                                            input logic [5:0] sh);
        logic [64:0] p;
        p = 65'(v) * 65'(m);
        return 32'(p >> sh);
    endfunction

    // (a * b) >> 30, a and b below 2^32
    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >> 30);
    endfunction

endpackage

@@ rtl/quasi_periodic_covariance_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// quasi_periodic_covariance_top: pipelined covariance element generator
// amp * exp(-0.5*(r/len)^2 + g*sin^2(p*r)), r = time_i - time_j, Q16.16 out; mode 1 drops the decay term.
// ============================================================================
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid/in_ready, time_i, time_j,    | into block
//          | row_tag, col_tag                      |
//  out     | out_valid/out_ready, covariance,      | out of block
//          | row_out, col_out                      |
//  cfg     | cfg_valid/cfg_ready, cfg_index,       | into block
//          | cfg_data                              |
//
// One item per cycle while the skid entry is free. Stage 0 loads at the accepting edge,
// then stages 1 through 30 follow in order, then the output register.
// The depth is set mostly by the sin and exp Horner chains, whose stages alternate
// a multiply with a divide by reciprocal multiply or by shift.
// Reset clears all valid bits and loads the register defaults.
// The pipeline advances as a whole while the skid entry behind the output
// register is free, so in_ready never depends on out_ready in the same cycle.
// cfg_ready is always high.
//
module quasi_periodic_covariance_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // item input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             time_i,
    input  logic signed [31:0]             time_j,
    input  logic [9:0]                     row_tag,
    input  logic [9:0]                     col_tag,
    // item output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    covariance,
    output logic [9:0]                     row_out,
    output logic [9:0]                     col_out,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int LAST = qpc_pkg::NUM_STAGES - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic               mode_reg;
    logic [31:0]        amplitude_reg;
    logic [31:0]        inv_length_reg;
    logic [31:0]        phase_scale_reg;
    logic signed [31:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            amplitude_reg   <= qpc_pkg::RST_AMPLITUDE;
            inv_length_reg  <= qpc_pkg::RST_INV_LENGTH;
            phase_scale_reg <= qpc_pkg::RST_PHASE;
            gain_reg        <= qpc_pkg::RST_GAIN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                qpc_pkg::CFG_MODE:       mode_reg        <= cfg_data[0];
                qpc_pkg::CFG_AMPLITUDE:  amplitude_reg   <= cfg_data;
                qpc_pkg::CFG_INV_LENGTH: inv_length_reg  <= cfg_data;
                qpc_pkg::CFG_PHASE:      phase_scale_reg <= cfg_data;
                qpc_pkg::CFG_GAIN:       gain_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: whole pipe moves while the skid entry is free
    // ------------------------------------------------------------------
    logic                              adv;
    logic [qpc_pkg::NUM_STAGES-1:0]    valid_reg;
    qpc_pkg::tag_t                     tag_reg [0:LAST];
    qpc_pkg::tag_t                     in_tag;
    logic                              out_valid_reg;
    logic                              skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;
    assign in_tag   = '{row: row_tag, col: col_tag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[qpc_pkg::NUM_STAGES-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic [32:0]        a0_reg;            // |r|, Q16.16
    logic [63:0]        xp_reg [1:2];      // |r| * phase_scale, Q.40
    logic [63:0]        qd1_reg;           // |r| * inv_length, Q.40
    logic [22:0]        qe2_reg;           // quotient estimate by pi
    logic [27:0]        dcy_reg [2:16];    // decay term, Q.16
    logic [43:0]        rem3_reg;
    logic [41:0]        red4_reg;          // phase mod pi
    logic [30:0]        x_reg [5:13];      // folded phase, Q.30
    logic [31:0]        x2_reg [6:11];
    logic [31:0]        tv_reg [7:13];     // sin Horner: t, then products
    logic [30:0]        s14_reg;
    logic [30:0]        sin2_15_reg;
    logic signed [24:0] p16_reg;
    logic signed [29:0] e17_reg;
    logic               und_reg [18:30];
    logic signed [9:0]  k_reg [18:30];
    logic [15:0]        f18_reg;
    logic [29:0]        zz_reg [19:28];
    logic [31:0]        te_reg [20:29];    // exp Horner
    logic [62:0]        prod30_reg;

    // next values of the computing stages
    logic signed [32:0] diff;
    logic [32:0]        a0_next;
    logic [63:0]        xp1_next;
    logic [63:0]        qd1_next;
    logic [22:0]        qe2_next;
    logic [25:0]        h;
    logic [51:0]        hsq;
    logic [27:0]        dcy2_next;
    logic [43:0]        rem3_next;
    logic [41:0]        red4_next;
    logic [41:0]        fold;
    logic [30:0]        x5_next;
    logic [31:0]        x2_6_next;
    logic [63:0]        sp;
    logic [30:0]        s_raw;
    logic [30:0]        s14_next;
    logic [61:0]        ssq;
    logic [30:0]        sin2_15_next;
    logic signed [63:0] pp;
    logic signed [24:0] p16_next;
    logic signed [29:0] e17_next;
    logic signed [63:0] yp;
    logic signed [9:0]  k18_next;
    logic [15:0]        f18_next;
    logic               und18_next;
    logic [45:0]        zp;
    logic [29:0]        z19_next;
    logic [62:0]        prod30_next;

    always_comb
    begin
        diff     = $signed({time_i[31], time_i}) - $signed({time_j[31], time_j});
        a0_next  = diff[32] ? 33'(-diff) : 33'(diff);

        xp1_next = 64'(a0_reg) * 64'(phase_scale_reg);
        qd1_next = 64'(a0_reg) * 64'(inv_length_reg);

        qe2_next = 23'((64'(xp_reg[1][63:32]) * 64'(qpc_pkg::PI_RECIP)) >> 32);
        h        = qd1_reg[45:20];
        hsq      = 52'(h) * 52'(h);
        if (mode_reg)
            dcy2_next = '0;
        else if (qd1_reg[63:46] != '0)
            dcy2_next = qpc_pkg::DECAY_CAP;
        else
            dcy2_next = 28'(hsq >> 25);

        rem3_next = 44'(xp_reg[2] - 64'(qe2_reg) * 64'(qpc_pkg::PI40));

        // estimate is at most two below the true quotient
        if (rem3_reg >= qpc_pkg::PI40_X2)
            red4_next = 42'(rem3_reg - qpc_pkg::PI40_X2);
        else if (rem3_reg >= qpc_pkg::PI40_X1)
            red4_next = 42'(rem3_reg - qpc_pkg::PI40_X1);
        else
            red4_next = 42'(rem3_reg);

        fold      = (red4_reg > qpc_pkg::HALF_PI40) ? qpc_pkg::PI40 - red4_reg : red4_reg;
        x5_next   = 31'(fold >> 10);
        x2_6_next = qpc_pkg::mul_q30(32'(x_reg[5]), 32'(x_reg[5]));

        sp       = 64'(x_reg[13]) * 64'(tv_reg[13]);
        s_raw    = 31'(sp >> 30);
        s14_next = (32'(s_raw) > qpc_pkg::ONE30) ? 31'(qpc_pkg::ONE30) : s_raw;
        ssq      = 62'(s14_reg) * 62'(s14_reg);
        sin2_15_next = 31'(ssq >> 30);

        pp       = 64'(gain_reg) * $signed({33'd0, sin2_15_reg});
        p16_next = 25'(pp >>> 38);
        e17_next = 30'(p16_reg) - $signed({2'b00, dcy_reg[16]});

        und18_next = (e17_reg < qpc_pkg::EXP_MIN);
        yp         = 64'(e17_reg) * $signed({32'd0, qpc_pkg::LOG2E30});
        k18_next   = 10'(yp >>> 46);
        f18_next   = yp[45:30];
        zp         = 46'(f18_reg) * 46'(qpc_pkg::LN2_30);
        z19_next   = 30'(zp >> 16);

        prod30_next = 63'(64'(amplitude_reg) * 64'(te_reg[29]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i <= LAST; i++)
                tag_reg[i] <= tag_reg[i-1];

            a0_reg    <= a0_next;
            xp_reg[1] <= xp1_next;
            xp_reg[2] <= xp_reg[1];
            qd1_reg   <= qd1_next;
            qe2_reg   <= qe2_next;

            dcy_reg[2] <= dcy2_next;
            for (int i = 3; i <= 16; i++)
                dcy_reg[i] <= dcy_reg[i-1];

            rem3_reg <= rem3_next;
            red4_reg <= red4_next;

            x_reg[5] <= x5_next;
            for (int i = 6; i <= 13; i++)
                x_reg[i] <= x_reg[i-1];
            x2_reg[6] <= x2_6_next;
            for (int i = 7; i <= 11; i++)
                x2_reg[i] <= x2_reg[i-1];

            // sin series: 1 - x^2/72, /42, /20, /6
            tv_reg[7]  <= qpc_pkg::ONE30 - qpc_pkg::mul_shr(x2_reg[6], qpc_pkg::M72,
                                                           qpc_pkg::SH72);
            tv_reg[8]  <= qpc_pkg::mul_q30(x2_reg[7], tv_reg[7]);
            tv_reg[9]  <= qpc_pkg::ONE30 - qpc_pkg::mul_shr(tv_reg[8], qpc_pkg::M42,
                                                           qpc_pkg::SH42);
            tv_reg[10] <= qpc_pkg::mul_q30(x2_reg[9], tv_reg[9]);
            tv_reg[11] <= qpc_pkg::ONE30 - qpc_pkg::mul_shr(tv_reg[10], qpc_pkg::M20,
                                                           qpc_pkg::SH20);
            tv_reg[12] <= qpc_pkg::mul_q30(x2_reg[11], tv_reg[11]);
            tv_reg[13] <= qpc_pkg::ONE30 - qpc_pkg::mul_shr(tv_reg[12], qpc_pkg::M6,
                                                           qpc_pkg::SH6);

            s14_reg     <= s14_next;
            sin2_15_reg <= sin2_15_next;
            p16_reg     <= p16_next;
            e17_reg     <= e17_next;

            und_reg[18] <= und18_next;
            k_reg[18]   <= k18_next;
            for (int i = 19; i <= 30; i++)
            begin
                und_reg[i] <= und_reg[i-1];
                k_reg[i]   <= k_reg[i-1];
            end
            f18_reg <= f18_next;

            zz_reg[19] <= z19_next;
            for (int i = 20; i <= 28; i++)
                zz_reg[i] <= zz_reg[i-1];

            // exp series: 1 + z/n * (...), n = 7 down to 1
            te_reg[20] <= qpc_pkg::ONE30 + qpc_pkg::mul_shr(32'(zz_reg[19]), qpc_pkg::M7,
                                                           qpc_pkg::SH7);
            te_reg[21] <= qpc_pkg::mul_q30(32'(zz_reg[20]), te_reg[20]);
            te_reg[22] <= qpc_pkg::ONE30 + qpc_pkg::mul_shr(te_reg[21], qpc_pkg::M6,
                                                           qpc_pkg::SH6);
            te_reg[23] <= qpc_pkg::mul_q30(32'(zz_reg[22]), te_reg[22]);
            te_reg[24] <= qpc_pkg::ONE30 + qpc_pkg::mul_shr(te_reg[23], qpc_pkg::M5,
                                                           qpc_pkg::SH5);
            te_reg[25] <= qpc_pkg::ONE30
                          + (qpc_pkg::mul_q30(32'(zz_reg[24]), te_reg[24]) >> 2);
            te_reg[26] <= qpc_pkg::mul_q30(32'(zz_reg[25]), te_reg[25]);
            te_reg[27] <= qpc_pkg::ONE30 + qpc_pkg::mul_shr(te_reg[26], qpc_pkg::M3,
                                                           qpc_pkg::SH3);
            te_reg[28] <= qpc_pkg::ONE30
                          + (qpc_pkg::mul_q30(32'(zz_reg[27]), te_reg[27]) >> 1);
            te_reg[29] <= qpc_pkg::ONE30 + qpc_pkg::mul_q30(32'(zz_reg[28]), te_reg[28]);

            prod30_reg <= prod30_next;
        end
    end

    // ------------------------------------------------------------------
    // final scale by 2^k with saturation
    // ------------------------------------------------------------------
    logic signed [10:0] kk;
    logic [10:0]        rs;
    logic [94:0]        shl;
    logic [62:0]        shr;
    logic [31:0]        cov_next;

    always_comb
    begin
        kk  = 11'(k_reg[30]) - 11'sd30;
        rs  = 11'(-kk);
        shl = 95'(prod30_reg) << kk[4:0];
        shr = prod30_reg >> rs[5:0];
        if (und_reg[30] || amplitude_reg == '0)
            cov_next = '0;
        else if (!kk[10])
        begin
            if (kk[9:5] != '0 || shl[94:32] != '0)
                cov_next = '1;
            else
                cov_next = shl[31:0];
        end
        else if (rs[10:6] != '0)
            cov_next = '0;
        else if (shr[62:32] != '0)
            cov_next = '1;
        else
            cov_next = shr[31:0];
    end

    // ------------------------------------------------------------------
    // output register with one skid entry
    // ------------------------------------------------------------------
    logic          push;
    logic          pop;
    logic          out_valid_next;
    logic          skid_valid_next;
    logic          head_from_new;
    logic          head_from_skid;
    logic          skid_load;
    logic [31:0]   head_cov_reg;
    logic [31:0]   skid_cov_reg;
    qpc_pkg::tag_t head_tag_reg;
    qpc_pkg::tag_t skid_tag_reg;

    assign push = adv && valid_reg[LAST];
    assign pop  = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_from_new   = 1'b0;
        head_from_skid  = 1'b0;
        skid_load       = 1'b0;
        if (!out_valid_reg)
        begin
            out_valid_next = push;
            head_from_new  = push;
        end
        else if (!skid_valid_reg)
        begin
            if (pop && push)
                head_from_new = 1'b1;
            else if (pop)
                out_valid_next = 1'b0;
            else if (push)
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            head_from_skid  = 1'b1;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_from_new)
        begin
            head_cov_reg <= cov_next;
            head_tag_reg <= tag_reg[LAST];
        end
        else if (head_from_skid)
        begin
            head_cov_reg <= skid_cov_reg;
            head_tag_reg <= skid_tag_reg;
        end
        if (skid_load)
        begin
            skid_cov_reg <= cov_next;
            skid_tag_reg <= tag_reg[LAST];
        end
    end

    assign out_valid  = out_valid_reg;
    assign covariance = head_cov_reg;
    assign row_out    = head_tag_reg.row;
    assign col_out    = head_tag_reg.col;

endmodule

@@ rtl/qpc_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// qpc_checker: port-level checks for the covariance block
// Output hold under stall, back-pressure behavior, config always ready.
// ============================================================================
module qpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] covariance,
    input logic [9:0]  row_out,
    input logic [9:0]  col_out,
    input logic        cfg_ready
);

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(covariance)
                                    && $stable(row_out) && $stable(col_out))
        else $error("output item changed while stalled");

    // input back-pressure only with a result waiting
    a_bp_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no output item");

    // a taken result frees the skid entry
    a_bp_release: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("in_ready stayed low after output drained");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind quasi_periodic_covariance_top qpc_checker u_qpc_checker (.*);
